[rtl/core/motor_soft_start_with_link_qualifier_assert.svh]
// Assertion macros shared by the motor soft start RTL.
// Both macros sample on the module's clock and are disabled while reset is high.
`ifndef MOTOR_SOFT_START_WITH_LINK_QUALIFIER_ASSERT_SVH
`define MOTOR_SOFT_START_WITH_LINK_QUALIFIER_ASSERT_SVH

// Same-cycle implication.
`define MSSQ_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define MSSQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/mssq_pkg.sv]
// Package for the motor soft start with link qualifier.
// Holds register indexes, reset values and the status struct; no dependencies.
package mssq_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ON_THRESHOLD     = 3'd0,
      CSR_OFF_THRESHOLD    = 3'd1,
      CSR_FRAME_LENGTH     = 3'd2,
      CSR_COMMAND_POSITION = 3'd3,
      CSR_DEBOUNCE_TICKS   = 3'd4,
      CSR_RAMP_UP_STEP     = 3'd5,
      CSR_RAMP_DOWN_STEP   = 3'd6,
      CSR_DRIVE_MAX        = 3'd7
   } csr_index_type;

   localparam logic [7:0] RST_ON_THRESHOLD     = 8'd99;
   localparam logic [7:0] RST_OFF_THRESHOLD    = 8'd49;
   localparam logic [3:0] RST_FRAME_LENGTH     = 4'd4;
   localparam logic [2:0] RST_COMMAND_POSITION = 3'd1;
   localparam logic [4:0] RST_DEBOUNCE_TICKS   = 5'd21;
   localparam logic [7:0] RST_RAMP_UP_STEP     = 8'd1;
   localparam logic [7:0] RST_RAMP_DOWN_STEP   = 8'd3;
   localparam logic [7:0] RST_DRIVE_MAX        = 8'd60;

   // Per-tick flags that ride along with the speed to the result.
   typedef struct packed {
      logic motor_enabled;
      logic link_up;
   } status_type;

endpackage

[rtl/core/mssq_scale.sv]
// Drive scaling pipeline: floor(speed * drive_max / SPEED_FULL) plus result register.
// Depends on mssq_pkg and the assertion macro header.
`include "motor_soft_start_with_link_qualifier_assert.svh"

module mssq_scale
   import mssq_pkg::*;
#(
   parameter int unsigned SPEED_FULL = 255
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  logic [$clog2(SPEED_FULL+1)-1:0]       in_speed,
   input  status_type                            in_stat,
   input  logic [7:0]                            drive_max,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output logic [7:0]                            out_drive,
   output logic [7:0]                            out_speed,
   output status_type                            out_stat
);

   localparam int unsigned SPEED_W = $clog2(SPEED_FULL + 1);
   localparam int unsigned PROD_W  = SPEED_W + 8;
   localparam int unsigned WIDE_W  = 2 * PROD_W;
   // floor(2^PROD_W / SPEED_FULL): estimate is low by at most one
   localparam longint unsigned RECIP_L = (64'd1 << PROD_W) / SPEED_FULL;
   localparam logic [PROD_W-1:0] RECIP = RECIP_L[PROD_W-1:0];
   localparam logic [PROD_W-1:0] DIV   = PROD_W'(SPEED_FULL);
   localparam logic [PROD_W-1:0] DIV2  = PROD_W'(2 * SPEED_FULL);

   // stage a: captured speed
   logic               a_valid_ff;
   logic [SPEED_W-1:0] a_speed_ff;
   status_type         a_stat_ff;
   // stage b: product
   logic               b_valid_ff;
   logic [PROD_W-1:0]  b_prod_ff, b_prod_in;
   logic [7:0]         b_speed_ff;
   status_type         b_stat_ff;
   // stage c: quotient estimate
   logic               c_valid_ff;
   logic [PROD_W-1:0]  c_prod_ff;
   logic [PROD_W-1:0]  c_est_ff, c_est_in;
   logic [WIDE_W-1:0]  c_wide;
   logic [7:0]         c_speed_ff;
   status_type         c_stat_ff;
   // output register
   logic               o_valid_ff;
   logic [7:0]         o_drive_ff, o_drive_in;
   logic [7:0]         o_speed_ff;
   status_type         o_stat_ff;

   logic               a_ready, b_ready, c_ready, o_ready;
   logic [PROD_W-1:0]  est_mul, rem_w, quot_w;

   assign o_ready = !o_valid_ff || out_ready;
   assign c_ready = !c_valid_ff || o_ready;
   assign b_ready = !b_valid_ff || c_ready;
   assign a_ready = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   always_comb begin
      b_prod_in = PROD_W'(a_speed_ff) * PROD_W'(drive_max);
      c_wide    = WIDE_W'(b_prod_ff) * WIDE_W'(RECIP);
      c_est_in  = c_wide[WIDE_W-1:PROD_W];
      est_mul   = PROD_W'(c_est_ff * DIV);
      rem_w     = c_prod_ff - est_mul;
      quot_w    = (rem_w >= DIV) ? c_est_ff + PROD_W'(1) : c_est_ff;
      o_drive_in = quot_w[7:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         if (a_ready) a_valid_ff <= in_valid;
         if (b_ready) b_valid_ff <= a_valid_ff;
         if (c_ready) c_valid_ff <= b_valid_ff;
         if (o_ready) o_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && in_valid) begin
         a_speed_ff <= in_speed;
         a_stat_ff  <= in_stat;
      end
      if (b_ready && a_valid_ff) begin
         b_prod_ff  <= b_prod_in;
         b_speed_ff <= 8'(a_speed_ff);
         b_stat_ff  <= a_stat_ff;
      end
      if (c_ready && b_valid_ff) begin
         c_prod_ff  <= b_prod_ff;
         c_est_ff   <= c_est_in;
         c_speed_ff <= b_speed_ff;
         c_stat_ff  <= b_stat_ff;
      end
      if (o_ready && c_valid_ff) begin
         o_drive_ff <= o_drive_in;
         o_speed_ff <= c_speed_ff;
         o_stat_ff  <= c_stat_ff;
      end
   end

   assign out_valid = o_valid_ff;
   assign out_drive = o_drive_ff;
   assign out_speed = o_speed_ff;
   assign out_stat  = o_stat_ff;

   `MSSQ_ASSERT_SAME(a_est_within_one, c_valid_ff, rem_w < DIV2, "quotient estimate off by more than one")
   `MSSQ_ASSERT_NEXT(a_est_held_on_stall, c_valid_ff && !o_ready, c_valid_ff && $stable(c_est_ff), "stalled estimate moved")
   `MSSQ_ASSERT_NEXT(a_out_held, out_valid && !out_ready, out_valid && $stable(out_drive), "stalled result moved")

endmodule

[rtl/core/motor_soft_start_with_link_qualifier.sv]
// Top level of the motor soft start with link qualifier.
// Depends on mssq_pkg, mssq_scale and the assertion macro header.
//
// Usage:
//   csr_*  : register writes (index, 8-bit data); always ready, one per cycle.
//            Write only while no transaction is in flight.
//   req_*  : one transaction per scheduler tick: link pin level, byte-valid
//            flag and received byte.
//   rsp_*  : one transaction per request: drive value, ramped speed, enable
//            and debounced link flag, all as of the end of that tick.
// Throughput: one request per cycle while rsp_ready keeps the pipeline moving.
//   Each result passes through the scale pipeline (capture, speed * drive_max,
//   reciprocal multiply, remainder correction into the result register).
// Tick state (frame position, enable, speed, debounce) updates in the cycle
//   a request is accepted, so the next request can follow immediately.
// Reset: registers return to defaults (on 99, off 49, frame 4, position 1,
//   debounce 21, up 1, down 3, drive max 60); speed, enable and link clear,
//   and a frame clear is pending for the first tick.
// Stall: when rsp_ready is low the result holds; requests keep flowing until
//   the four pipeline slots fill, then req_ready drops.
`include "motor_soft_start_with_link_qualifier_assert.svh"

module motor_soft_start_with_link_qualifier
   import mssq_pkg::*;
#(
   parameter int unsigned SPEED_FULL = 255
) (
   input  logic                   clock,
   input  logic                   reset,
   // register write channel
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   // tick request channel
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_link_pin,
   input  logic                   req_byte_valid,
   input  logic [7:0]             req_rx_byte,
   // result channel
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_drive_value,
   output logic [7:0]             rsp_speed_level,
   output logic                   rsp_motor_enabled,
   output logic                   rsp_link_up
);

   localparam int unsigned SPEED_W = $clog2(SPEED_FULL + 1);
   localparam int unsigned SUM_W   = ((SPEED_W > 8) ? SPEED_W : 8) + 1;
   localparam logic [SPEED_W-1:0] SPEED_MAX = SPEED_W'(SPEED_FULL);

   // configuration registers
   logic [7:0] on_threshold_ff;
   logic [7:0] off_threshold_ff;
   logic [3:0] frame_length_ff;
   logic [2:0] command_position_ff;
   logic [4:0] debounce_ticks_ff;
   logic [7:0] ramp_up_ff;
   logic [7:0] ramp_down_ff;
   logic [7:0] drive_max_ff;

   // tick state
   logic [3:0]         frame_pos_ff, frame_pos_in;
   logic               pos_valid_ff, pos_valid_in;
   logic               enable_ff, enable_in;
   logic               clear_pending_ff, clear_pending_in;
   logic [SPEED_W-1:0] speed_ff, speed_in;
   logic [4:0]         debounce_count_ff, debounce_count_in;
   logic               link_flag_ff, link_flag_in;

   logic               accept;
   logic               pos_valid_eff;
   logic [4:0]         pos_step;
   logic [SUM_W-1:0]   sum_up;
   logic [5:0]         count_step;
   status_type         stat_in;
   status_type         rsp_stat;

   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         on_threshold_ff     <= RST_ON_THRESHOLD;
         off_threshold_ff    <= RST_OFF_THRESHOLD;
         frame_length_ff     <= RST_FRAME_LENGTH;
         command_position_ff <= RST_COMMAND_POSITION;
         debounce_ticks_ff   <= RST_DEBOUNCE_TICKS;
         ramp_up_ff          <= RST_RAMP_UP_STEP;
         ramp_down_ff        <= RST_RAMP_DOWN_STEP;
         drive_max_ff        <= RST_DRIVE_MAX;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_ON_THRESHOLD:     on_threshold_ff     <= csr_data;
            CSR_OFF_THRESHOLD:    off_threshold_ff    <= csr_data;
            CSR_FRAME_LENGTH:     frame_length_ff     <= csr_data[3:0];
            CSR_COMMAND_POSITION: command_position_ff <= csr_data[2:0];
            CSR_DEBOUNCE_TICKS:   debounce_ticks_ff   <= csr_data[4:0];
            CSR_RAMP_UP_STEP:     ramp_up_ff          <= csr_data;
            CSR_RAMP_DOWN_STEP:   ramp_down_ff        <= csr_data;
            CSR_DRIVE_MAX:        drive_max_ff        <= csr_data;
         endcase
      end
   end

   // one tick: command, then speed, then link qualifier
   always_comb begin
      // a clear left by a down link wipes frame position and enable first
      pos_valid_eff = pos_valid_ff && !clear_pending_ff;
      enable_in     = enable_ff && !clear_pending_ff;
      pos_valid_in  = pos_valid_eff;
      frame_pos_in  = frame_pos_ff;
      pos_step      = pos_valid_eff ? {1'b0, frame_pos_ff} + 5'd1 : 5'd0;
      if (req_byte_valid) begin
         frame_pos_in = (pos_step >= {1'b0, frame_length_ff}) ? 4'd0 : pos_step[3:0];
         pos_valid_in = 1'b1;
         if (frame_pos_in == {1'b0, command_position_ff}) begin
            // on wins when both thresholds match
            if (req_rx_byte >= on_threshold_ff) begin
               enable_in = 1'b1;
            end else if (req_rx_byte <= off_threshold_ff) begin
               enable_in = 1'b0;
            end
         end
      end
      // takes effect one tick later
      clear_pending_in = !link_flag_ff;

      // speed ramp uses the link flag from before this tick
      sum_up = SUM_W'(speed_ff) + SUM_W'(ramp_up_ff);
      if (enable_in && link_flag_ff) begin
         speed_in = (sum_up >= SUM_W'(SPEED_MAX)) ? SPEED_MAX : sum_up[SPEED_W-1:0];
      end else if (SUM_W'(speed_ff) <= SUM_W'(ramp_down_ff)) begin
         speed_in = '0;
      end else begin
         speed_in = speed_ff - SPEED_W'(ramp_down_ff);
      end

      // saturating debounce
      count_step = req_link_pin ? {1'b0, debounce_count_ff} + 6'd1 : 6'd0;
      debounce_count_in = (count_step >= {1'b0, debounce_ticks_ff}) ?
                          debounce_ticks_ff : count_step[4:0];
      link_flag_in = link_flag_ff;
      if (req_link_pin && (debounce_count_in == debounce_ticks_ff)) begin
         link_flag_in = 1'b1;
      end
      if (!req_link_pin) begin
         link_flag_in = 1'b0;
      end

      stat_in.motor_enabled = enable_in;
      stat_in.link_up       = link_flag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_valid_ff      <= 1'b0;
         enable_ff         <= 1'b0;
         clear_pending_ff  <= 1'b1;
         speed_ff          <= '0;
         debounce_count_ff <= '0;
         link_flag_ff      <= 1'b0;
      end else if (accept) begin
         pos_valid_ff      <= pos_valid_in;
         enable_ff         <= enable_in;
         clear_pending_ff  <= clear_pending_in;
         speed_ff          <= speed_in;
         debounce_count_ff <= debounce_count_in;
         link_flag_ff      <= link_flag_in;
      end
   end

   // position is qualified by pos_valid_ff
   always_ff @(posedge clock) begin
      if (accept) begin
         frame_pos_ff <= frame_pos_in;
      end
   end

   mssq_scale #(
      .SPEED_FULL(SPEED_FULL)
   ) u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_speed  (speed_in),
      .in_stat   (stat_in),
      .drive_max (drive_max_ff),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_drive (rsp_drive_value),
      .out_speed (rsp_speed_level),
      .out_stat  (rsp_stat)
   );

   assign rsp_motor_enabled = rsp_stat.motor_enabled;
   assign rsp_link_up       = rsp_stat.link_up;

   `MSSQ_ASSERT_NEXT(a_link_down_clears, accept && !link_flag_ff, clear_pending_ff && (speed_ff <= $past(speed_ff)), "down link did not schedule clear or speed rose")
   `MSSQ_ASSERT_NEXT(a_state_held_idle, !accept, $stable(speed_ff) && $stable(enable_ff) && $stable(link_flag_ff), "tick state changed without a transaction")
   `MSSQ_ASSERT_SAME(a_speed_capped, 1'b1, speed_ff <= SPEED_MAX, "speed above full scale")

endmodule

[test/mssq_tick_checker.sv]
`timescale 1ns / 1ps
// Result checker for motor_soft_start_with_link_qualifier: tracks register writes,
// predicts each tick's drive/speed/flags and checks the result channel in order.
// Depends on mssq_pkg for register indexes, reset values and status_type.
module mssq_tick_checker
   import mssq_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic                   req_link_pin,
   input  logic                   req_byte_valid,
   input  logic [7:0]             req_rx_byte,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [7:0]             rsp_drive_value,
   input  logic [7:0]             rsp_speed_level,
   input  logic                   rsp_motor_enabled,
   input  logic                   rsp_link_up,
   output int unsigned            fault_count,
   output int unsigned            pending_count
);

   localparam int unsigned FULL_SPEED   = 255;
   localparam int unsigned REPORT_LIMIT = 10;

   typedef struct packed {
      logic [7:0] drive;
      logic [7:0] speed;
      status_type flags;
   } tick_out_type;

   // register shadow
   logic [7:0] on_thr, off_thr, up_step, dn_step, drv_max;
   logic [3:0] frm_len;
   logic [2:0] cmd_pos;
   logic [4:0] deb_ticks;

   // tick state
   logic [3:0] frm_pos;
   logic       pos_held, enable_on, clear_due, link_on;
   logic [7:0] speed;
   logic [4:0] deb_count;

   tick_out_type tick_q[$];
   int unsigned  faults = 0;

   task automatic restore_defaults();
      on_thr    = RST_ON_THRESHOLD;
      off_thr   = RST_OFF_THRESHOLD;
      frm_len   = RST_FRAME_LENGTH;
      cmd_pos   = RST_COMMAND_POSITION;
      deb_ticks = RST_DEBOUNCE_TICKS;
      up_step   = RST_RAMP_UP_STEP;
      dn_step   = RST_RAMP_DOWN_STEP;
      drv_max   = RST_DRIVE_MAX;
      frm_pos   = '0;
      pos_held  = 1'b0;
      enable_on = 1'b0;
      clear_due = 1'b1;
      speed     = '0;
      deb_count = '0;
      link_on   = 1'b0;
   endtask

   task automatic set_reg(input csr_index_type idx, input logic [7:0] val);
      case (idx)
         CSR_ON_THRESHOLD:     on_thr    = val;
         CSR_OFF_THRESHOLD:    off_thr   = val;
         CSR_FRAME_LENGTH:     frm_len   = val[3:0];
         CSR_COMMAND_POSITION: cmd_pos   = val[2:0];
         CSR_DEBOUNCE_TICKS:   deb_ticks = val[4:0];
         CSR_RAMP_UP_STEP:     up_step   = val;
         CSR_RAMP_DOWN_STEP:   dn_step   = val;
         CSR_DRIVE_MAX:        drv_max   = val;
         default: ;
      endcase
   endtask

   // One tick: command part, then speed, then link debounce.
   function automatic tick_out_type advance_tick(input logic pin, input logic bvalid,
                                                 input logic [7:0] rx);
      logic         link_prev;
      int unsigned  next_pos, level, cnt;
      tick_out_type res;
      link_prev = link_on;
      if (clear_due) begin
         pos_held  = 1'b0;
         frm_pos   = '0;
         enable_on = 1'b0;
         clear_due = 1'b0;
      end
      if (bvalid) begin
         next_pos = pos_held ? frm_pos + 1 : 0;
         if (next_pos >= frm_len) next_pos = 0;
         frm_pos  = 4'(next_pos);
         pos_held = 1'b1;
         if (frm_pos == {1'b0, cmd_pos}) begin
            if (rx >= on_thr) enable_on = 1'b1;
            else if (rx <= off_thr) enable_on = 1'b0;
         end
      end
      if (!link_prev) clear_due = 1'b1;

      if (enable_on && link_prev) begin
         level = speed + up_step;
         if (level >= FULL_SPEED) level = FULL_SPEED;
      end else if (speed <= dn_step) begin
         level = 0;
      end else begin
         level = speed - dn_step;
      end
      speed     = 8'(level);
      res.drive = 8'((level * drv_max) / FULL_SPEED);

      cnt = pin ? deb_count + 1 : 0;
      if (cnt >= deb_ticks) cnt = deb_ticks;
      deb_count = 5'(cnt);
      if (pin && cnt == deb_ticks) link_on = 1'b1;
      if (!pin) link_on = 1'b0;

      res.speed               = speed;
      res.flags.motor_enabled = enable_on;
      res.flags.link_up       = link_on;
      return res;
   endfunction

   always @(posedge clock) begin
      tick_out_type seen, want;
      if (reset) begin
         restore_defaults();
         tick_q.delete();
      end else begin
         if (csr_valid && csr_ready) set_reg(csr_index_type'(csr_index), csr_data);
         if (req_valid && req_ready)
            tick_q.push_back(advance_tick(req_link_pin, req_byte_valid, req_rx_byte));
         if (rsp_valid && rsp_ready) begin
            seen = {rsp_drive_value, rsp_speed_level, rsp_motor_enabled, rsp_link_up};
            if (tick_q.size() == 0) begin
               faults++;
               if (faults <= REPORT_LIMIT)
                  $display("%0t: result with nothing outstanding: drive %0d speed %0d en %0b link %0b",
                           $realtime, seen.drive, seen.speed, seen.flags.motor_enabled,
                           seen.flags.link_up);
            end else begin
               want = tick_q.pop_front();
               if (seen !== want) begin
                  faults++;
                  if (faults <= REPORT_LIMIT)
                     $display("%0t: mismatch exp drive %0d speed %0d en %0b link %0b, got drive %0d speed %0d en %0b link %0b",
                              $realtime, want.drive, want.speed, want.flags.motor_enabled,
                              want.flags.link_up, seen.drive, seen.speed,
                              seen.flags.motor_enabled, seen.flags.link_up);
               end
            end
         end
      end
      fault_count   <= faults;
      pending_count <= tick_q.size();
   end

endmodule

[test/motor_soft_start_with_link_qualifier_tb.sv]
`timescale 1ns / 1ps
// Top of the motor soft start testbench: clock, reset, stimulus and verdict.
// Depends on mssq_pkg, the block and mssq_tick_checker.
module motor_soft_start_with_link_qualifier_tb;
   import mssq_pkg::*;

   localparam int unsigned RUN_LIMIT     = 200000; // cycles before declaring a hang
   localparam int unsigned SETTLE_CYCLES = 8;      // pipeline is 4 deep; a bit of margin
   localparam int unsigned PHASE_ITEMS   = 100;
   localparam int unsigned PHASE_COUNT   = 8;

   // Receiver stall styles, re-rolled whenever sink_epoch wraps.
   typedef enum logic [1:0] {
      SINK_OPEN,    // always ready
      SINK_RANDOM,  // ready at random, with a three-in-four chance
      SINK_BURSTY   // long low/high stretches
   } sink_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   logic       req_valid      = 1'b0;
   logic       req_ready;
   logic       req_link_pin   = 1'b0;
   logic       req_byte_valid = 1'b0;
   logic [7:0] req_rx_byte    = '0;

   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_drive_value, rsp_speed_level;
   logic       rsp_motor_enabled, rsp_link_up;

   int unsigned fault_count, pending_count;

   // stimulus-side bookkeeping
   int unsigned   burst_left = 0;
   int unsigned   cycle_count = 0;
   logic [7:0]    cur_on  = RST_ON_THRESHOLD;
   logic [7:0]    cur_off = RST_OFF_THRESHOLD;
   sink_mode_type sink_mode = SINK_OPEN;
   int unsigned   sink_hold = 0;
   logic [6:0]    sink_epoch = '0;

   motor_soft_start_with_link_qualifier u_top (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_link_pin      (req_link_pin),
      .req_byte_valid    (req_byte_valid),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_drive_value   (rsp_drive_value),
      .rsp_speed_level   (rsp_speed_level),
      .rsp_motor_enabled (rsp_motor_enabled),
      .rsp_link_up       (rsp_link_up)
   );

   mssq_tick_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_link_pin      (req_link_pin),
      .req_byte_valid    (req_byte_valid),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_drive_value   (rsp_drive_value),
      .rsp_speed_level   (rsp_speed_level),
      .rsp_motor_enabled (rsp_motor_enabled),
      .rsp_link_up       (rsp_link_up),
      .fault_count       (fault_count),
      .pending_count     (pending_count)
   );

   always #10 clock = ~clock;

   // Hang guard: generous compared with the slowest legal run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("motor_soft_start_with_link_qualifier regression: fail");
         $finish;
      end
   end

   // Result-side back-pressure. The mode is re-rolled whenever sink_epoch wraps,
   // so that open stretches, scattered stalls and long stalls all hit the pipeline.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         sink_epoch <= sink_epoch + 1'b1;
         if (sink_epoch == '0) sink_mode <= sink_mode_type'($urandom_range(0, 2));
         case (sink_mode)
            SINK_OPEN:   rsp_ready <= 1'b1;
            SINK_RANDOM: rsp_ready <= ($urandom_range(0, 3) != 0);
            default: begin
               if (sink_hold == 0) begin
                  rsp_ready <= !rsp_ready;
                  sink_hold <= rsp_ready ? $urandom_range(1, 15) : $urandom_range(1, 6);
               end else begin
                  sink_hold <= sink_hold - 1;
               end
            end
         endcase
      end
   end

   // Holds csr_valid high until the write transaction is taken; the caller
   // drops it once the whole register set is written.
   task automatic write_reg(input csr_index_type idx, input logic [7:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Writes every register. Only called with the block idle.
   task automatic configure(input logic [7:0] on_v, input logic [7:0] off_v,
                            input logic [3:0] frame_v, input logic [2:0] pos_v,
                            input logic [4:0] deb_v, input logic [7:0] up_v,
                            input logic [7:0] dn_v, input logic [7:0] max_v);
      write_reg(CSR_ON_THRESHOLD, on_v);
      write_reg(CSR_OFF_THRESHOLD, off_v);
      write_reg(CSR_FRAME_LENGTH, {4'd0, frame_v});
      write_reg(CSR_COMMAND_POSITION, {5'd0, pos_v});
      write_reg(CSR_DEBOUNCE_TICKS, {3'd0, deb_v});
      write_reg(CSR_RAMP_UP_STEP, up_v);
      write_reg(CSR_RAMP_DOWN_STEP, dn_v);
      write_reg(CSR_DRIVE_MAX, max_v);
      csr_valid <= 1'b0;
      cur_on  = on_v;
      cur_off = off_v;
   endtask

   // Stop sending and wait for every outstanding result. The first edge lets
   // the checker's count catch up with a request taken at this very edge.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One tick transaction. Traffic comes in bursts with random gaps between
   // them; a zero gap gives long stretches with valid held high.
   task automatic send_tick(input logic pin, input logic bvalid, input logic [7:0] rx);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_link_pin   <= pin;
      req_byte_valid <= bvalid;
      req_rx_byte    <= rx;
      do @(posedge clock); while (!req_ready);
   endtask

   // Bytes cluster at the rails and around both thresholds, where the
   // compare decisions flip.
   function automatic logic [7:0] pick_byte();
      int v;
      case ($urandom_range(0, 3))
         0:       v = $urandom_range(0, 1) ? 255 : 0;
         1:       v = int'(cur_on) + int'($urandom_range(0, 4)) - 2;
         2:       v = int'(cur_off) + int'($urandom_range(0, 4)) - 2;
         default: v = $urandom_range(0, 255);
      endcase
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return 8'(v);
   endfunction

   initial begin
      int unsigned drop_pm, low_left;
      logic        pin;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // --- directed ---
      // Reset settings, link still down: bytes are taken, but the pending frame
      // clear wipes the position and enable each tick, so none is compared.
      send_tick(1'b0, 1'b1, 8'hFF);
      send_tick(1'b0, 1'b1, 8'hFF);
      send_tick(1'b1, 1'b0, 8'h00);
      drain();

      // Overlapping thresholds (on wins), zero frame length so every byte sits
      // at position 0, zero debounce, full-size steps, drive max 180.
      configure(8'd50, 8'd200, 4'd0, 3'd0, 5'd0, 8'd255, 8'd255, 8'd180);
      send_tick(1'b1, 1'b0, 8'h00);
      send_tick(1'b1, 1'b1, 8'd100);
      send_tick(1'b1, 1'b0, 8'h00);
      send_tick(1'b1, 1'b1, 8'h00);
      send_tick(1'b1, 1'b1, 8'hFF);
      send_tick(1'b0, 1'b1, 8'hAA);
      send_tick(1'b0, 1'b1, 8'hFF);   // byte while link down: enable set, then cleared
      send_tick(1'b1, 1'b0, 8'h00);
      send_tick(1'b1, 1'b1, 8'hFF);
      send_tick(1'b1, 1'b0, 8'h00);
      drain();

      // Command position beyond the frame: no byte is ever compared, even
      // though an on threshold of zero would accept anything.
      configure(8'd0, 8'd0, 4'd3, 3'd7, 5'd5, 8'd0, 8'd0, 8'd0);
      repeat (6) send_tick(1'b1, 1'b1, 8'h55);
      drain();

      // Debounce lowered below the current count: clamps on the next high tick.
      configure(8'd0, 8'd0, 4'd3, 3'd7, 5'd2, 8'd7, 8'd1, 8'd1);
      send_tick(1'b1, 1'b1, 8'hFF);
      send_tick(1'b1, 1'b0, 8'h00);
      send_tick(1'b0, 1'b0, 8'h00);

      // --- random ---
      // Each phase drains (so the sender fully pauses), rewrites every
      // register, then runs mostly link-up traffic with occasional drops.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         drain();
         case (phase)
            0: configure(8'd255, 8'd0, 4'd8, 3'd7, 5'd31, 8'd255, 8'd255, 8'd180);
            1: configure(8'd0, 8'd255, 4'd1, 3'd0, 5'd1, 8'd0, 8'd0, 8'd0);
            PHASE_COUNT - 1:
               configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 4'd15,
                         3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)),
                         8'($urandom_range(0, 40)), 8'($urandom_range(0, 40)), 8'd255);
            default:
               configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                                     : 4'($urandom_range(1, 8)),
                         3'($urandom_range(0, 7)),
                         ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                     : 5'($urandom_range(0, 8)),
                         8'($urandom_range(0, 64)), 8'($urandom_range(0, 64)),
                         8'($urandom_range(0, 180)));
         endcase

         case ($urandom_range(0, 2))
            0:       drop_pm = 5;
            1:       drop_pm = 20;
            default: drop_pm = 120;
         endcase
         low_left = 0;

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (low_left != 0) begin
               pin = 1'b0;
               low_left--;
            end else if ($urandom_range(0, 999) < drop_pm) begin
               pin = 1'b0;
               low_left = $urandom_range(0, 3);
            end else begin
               pin = 1'b1;
            end
            send_tick(pin, ($urandom_range(0, 9) < 7), pick_byte());
         end
      end

      drain();
      if (fault_count == 0)
         $display("motor_soft_start_with_link_qualifier regression: pass");
      else
         $display("motor_soft_start_with_link_qualifier regression: fail");
      $finish;
   end

endmodule
